// ===== hdl/square_wave_note_sequencer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Square-wave note sequencer assertion macros
// Implication checks on the rising clock edge, gated off while reset is low.
// ----------------------------------------------------------------------------
`ifndef SQUARE_WAVE_NOTE_SEQUENCER_CORE_ASSERT_SVH
`define SQUARE_WAVE_NOTE_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define SWNS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swns check failed");

// next-cycle implication
`define SWNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swns check failed");

`endif

// ===== hdl/swns_pkg.sv =====
// ----------------------------------------------------------------------------
// swns_pkg
// Types, register indexes and the note period table of the sequencer.
// ----------------------------------------------------------------------------
package swns_pkg;

    localparam int PERIOD_BITS = 8;   // largest period is 168
    localparam int DIV_BITS    = 9;   // largest divisor is 2 * 168
    localparam int GAIN_BITS   = 15;
    localparam int NLEN_BITS   = 20;
    localparam int SEQ_BITS    = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 20;
    localparam int CFG_ADDR_BITS = 2;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 15'd5000;
    localparam logic [NLEN_BITS-1:0] NLEN_RESET = 20'd11025;
    localparam logic [SEQ_BITS-1:0]  SEQ_RESET  = 4'd12;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_GAIN      = 2'd0,
        REG_NOTE_LEN  = 2'd1,
        REG_SEQ_LEN   = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_A,   // counter mod 2p
        ST_SPLIT,   // derive waves of period p and 2p
        ST_DIV_B,   // counter mod p/2
        ST_FORM     // form sample, advance note
    } t_state;

    // 44100 / f truncated; entries past twelve repeat the first four
    function automatic logic [PERIOD_BITS-1:0] note_period(input logic [SEQ_BITS-1:0] idx);
        logic [PERIOD_BITS-1:0] p;
        case (idx)
            4'd0:    p = 8'd168;
            4'd1:    p = 8'd150;
            4'd2:    p = 8'd133;
            4'd3:    p = 8'd126;
            4'd4:    p = 8'd112;
            4'd5:    p = 8'd100;
            4'd6:    p = 8'd89;
            4'd7:    p = 8'd100;
            4'd8:    p = 8'd112;
            4'd9:    p = 8'd126;
            4'd10:   p = 8'd133;
            4'd11:   p = 8'd150;
            4'd12:   p = 8'd168;
            4'd13:   p = 8'd150;
            4'd14:   p = 8'd133;
            4'd15:   p = 8'd126;
            default: p = 8'd168;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/square_wave_note_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// square_wave_note_sequencer_core
// Three-voice square-wave sequencer built on one restoring remainder unit.
// ----------------------------------------------------------------------------
// Steps: a tick word with tick high starts ST_DIV_A, the remainder unit working
//   out the counter mod 2p one bit per cycle; ST_SPLIT then derives two waves,
//   ST_DIV_B works out the counter mod p/2 and ST_FORM forms the sample once the
//   output register is free. A new tick word is taken only back in ST_IDLE.
// A tick word with tick low is taken while idle and yields nothing.
// Reset (sync, active low): counters and note index cleared, registers to defaults.
`include "square_wave_note_sequencer_core_assert.svh"

module square_wave_note_sequencer_core
    import swns_pkg::*;
#(
    parameter int TABLE_NOTES  = 12,   // 1..16
    parameter int COUNTER_BITS = 32    // 16..32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [CFG_BITS-1:0]       i_cfg_data,
    // tick words
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [0] tick, [7:1] zero
    // sample words
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [39:0]               m_axis_tdata    // [15:0] left_sample,
                                                      // [31:16] right_sample,
                                                      // [35:32] note_index,
                                                      // [39:36] zero
);

    localparam int BIT_W = $clog2(COUNTER_BITS);
    localparam logic [BIT_W-1:0]    LAST_BIT = BIT_W'(COUNTER_BITS - 1);
    localparam logic [SEQ_BITS:0]   NOTES_V  = (SEQ_BITS+1)'(TABLE_NOTES);

    // configuration
    logic [GAIN_BITS-1:0]   r_gain;
    logic [NLEN_BITS-1:0]   r_note_len;
    logic [SEQ_BITS-1:0]    r_seq_len;

    // sequencer state
    t_state                 r_state, n_state;
    logic [COUNTER_BITS-1:0] r_sample_counter, n_sample_counter;
    logic [NLEN_BITS-1:0]   r_in_note, n_in_note;
    logic [SEQ_BITS-1:0]    r_note, n_note;

    // remainder unit
    logic [PERIOD_BITS-1:0] r_period, n_period;
    logic [DIV_BITS-1:0]    r_div, n_div;
    logic [DIV_BITS-1:0]    r_rem, n_rem;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic                   r_wave_a, n_wave_a;
    logic                   r_wave_b, n_wave_b;

    // output register
    logic                   r_m_valid, n_m_valid;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [SEQ_BITS-1:0]    r_out_note, n_out_note;

    // shared datapath signals
    logic [DIV_BITS:0]      w_shift;
    logic                   w_ge;
    logic [DIV_BITS-1:0]    w_rem_step;
    logic [SEQ_BITS:0]      w_len;
    logic [DIV_BITS-1:0]    w_p_ext;
    logic [DIV_BITS-1:0]    w_mod_p;
    logic                   w_wave_c;
    logic                   w_load;
    logic [SEQ_BITS:0]      w_note_inc;
    logic [NLEN_BITS-1:0]   w_in_note_inc;
    logic [NLEN_BITS-1:0]   w_nlen;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'd0, r_out_note, r_sample, r_sample};

    // effective sequence length: zero acts as one, saturate at the table size
    always_comb begin
        if (r_seq_len == '0) begin
            w_len = (SEQ_BITS+1)'(1);
        end else if ({1'b0, r_seq_len} > NOTES_V) begin
            w_len = NOTES_V;
        end else begin
            w_len = {1'b0, r_seq_len};
        end
    end

    assign w_nlen = (r_note_len == '0) ? NLEN_BITS'(1) : r_note_len;

    // one restoring step: bring in the next counter bit, MSB first
    assign w_shift    = {r_rem, r_sample_counter[r_bit]};
    assign w_ge       = (w_shift >= {1'b0, r_div});
    assign w_rem_step = w_ge ? DIV_BITS'(w_shift - {1'b0, r_div}) : DIV_BITS'(w_shift);

    // mod 2p reduced to mod p with one conditional subtract
    assign w_p_ext  = {1'b0, r_period};
    assign w_mod_p  = (r_rem >= w_p_ext) ? (r_rem - w_p_ext) : r_rem;
    // third voice: r_rem holds counter mod (p/2), r_div holds p/2
    assign w_wave_c = (r_rem > (r_div >> 1));

    assign w_load        = !r_m_valid || m_axis_tready;
    assign w_note_inc    = {1'b0, r_note} + (SEQ_BITS+1)'(1);
    assign w_in_note_inc = r_in_note + NLEN_BITS'(1);

    always_comb begin
        n_state          = r_state;
        n_sample_counter = r_sample_counter;
        n_in_note        = r_in_note;
        n_note           = r_note;
        n_period         = r_period;
        n_div            = r_div;
        n_rem            = r_rem;
        n_bit            = r_bit;
        n_wave_a         = r_wave_a;
        n_wave_b         = r_wave_b;
        n_sample         = r_sample;
        n_out_note       = r_out_note;
        n_m_valid        = r_m_valid && !m_axis_tready;

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tdata[0]) begin
                    // note index past a shortened sequence restarts at zero
                    if ({1'b0, r_note} >= w_len) begin
                        n_note   = '0;
                        n_period = note_period('0);
                    end else begin
                        n_period = note_period(r_note);
                    end
                    n_div   = {n_period, 1'b0};
                    n_rem   = '0;
                    n_bit   = LAST_BIT;
                    n_state = ST_DIV_A;
                end
            end
            ST_DIV_A: begin
                n_rem = w_rem_step;
                n_bit = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    n_state = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                n_wave_b = (r_rem > w_p_ext);
                n_wave_a = (w_mod_p > DIV_BITS'(r_period >> 1));
                n_div    = DIV_BITS'(r_period >> 1);
                n_rem    = '0;
                n_bit    = LAST_BIT;
                n_state  = ST_DIV_B;
            end
            ST_DIV_B: begin
                n_rem = w_rem_step;
                n_bit = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    n_state = ST_FORM;
                end
            end
            ST_FORM: begin
                if (w_load) begin
                    // product of three +/-1 waves is positive for an even count of -1
                    if ((r_wave_a == r_wave_b) == w_wave_c) begin
                        n_sample = {1'b0, r_gain};
                    end else begin
                        n_sample = SAMPLE_BITS'(0) - {1'b0, r_gain};
                    end
                    n_out_note       = r_note;
                    n_m_valid        = 1'b1;
                    n_sample_counter = r_sample_counter + COUNTER_BITS'(1);
                    if (w_in_note_inc >= w_nlen) begin
                        n_in_note = '0;
                        n_note    = (w_note_inc >= w_len) ? '0 : w_note_inc[SEQ_BITS-1:0];
                    end else begin
                        n_in_note = w_in_note_inc;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_m_valid        <= 1'b0;
            r_sample_counter <= '0;
            r_in_note        <= '0;
            r_note           <= '0;
            r_gain           <= GAIN_RESET;
            r_note_len       <= NLEN_RESET;
            r_seq_len        <= SEQ_RESET;
        end else begin
            r_state          <= n_state;
            r_m_valid        <= n_m_valid;
            r_sample_counter <= n_sample_counter;
            r_in_note        <= n_in_note;
            r_note           <= n_note;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_GAIN:     r_gain     <= i_cfg_data[GAIN_BITS-1:0];
                    REG_NOTE_LEN: r_note_len <= i_cfg_data[NLEN_BITS-1:0];
                    REG_SEQ_LEN:  r_seq_len  <= i_cfg_data[SEQ_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_period   <= n_period;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_bit      <= n_bit;
        r_wave_a   <= n_wave_a;
        r_wave_b   <= n_wave_b;
        r_sample   <= n_sample;
        r_out_note <= n_out_note;
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    `SWNS_ASSERT_SAME(a_note_in_table, i_clk, i_rst_n, 1'b1, {1'b0, r_note} < NOTES_V)
    `SWNS_ASSERT_SAME(a_rem_below_div, i_clk, i_rst_n,
        (r_state == ST_DIV_A) || (r_state == ST_DIV_B), r_rem < r_div)
    `SWNS_ASSERT_NEXT(a_tick_starts, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tdata[0], r_state == ST_DIV_A)
    `SWNS_ASSERT_NEXT(a_counter_step, i_clk, i_rst_n,
        (r_state == ST_FORM) && w_load,
        r_sample_counter == COUNTER_BITS'($past(r_sample_counter) + COUNTER_BITS'(1)))
    `SWNS_ASSERT_SAME(a_out_note_valid, i_clk, i_rst_n,
        m_axis_tvalid, {1'b0, m_axis_tdata[35:32]} < NOTES_V)

endmodule
